[src/damped_particle_force_integrator_core_macros.svh]
// Assertion macros shared by the particle integrator RTL.
`ifndef DAMPED_PARTICLE_FORCE_INTEGRATOR_CORE_MACROS_SVH
`define DAMPED_PARTICLE_FORCE_INTEGRATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define DPFI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define DPFI_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/dpfi_pkg.sv]
// Types, codes and saturation helpers for the particle integrator.
package dpfi_pkg;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic [30:0]        reach;
        logic signed [31:0] strength;
    } item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] reaction_x;
        logic signed [31:0] reaction_y;
        logic               in_range;
    } result_t;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } unit_op_t;

    typedef struct packed {
        logic     start;
        unit_op_t op;
    } unit_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    localparam logic [2:0] FN_TICK     = 3'd0;
    localparam logic [2:0] FN_ADD      = 3'd1;
    localparam logic [2:0] FN_REPEL    = 3'd2;
    localparam logic [2:0] FN_ATTRACT  = 3'd3;
    localparam logic [2:0] FN_CW       = 3'd4;
    localparam logic [2:0] FN_CCW      = 3'd5;
    localparam logic [2:0] FN_PLACE    = 3'd6;
    localparam logic [2:0] FN_SPARE    = 3'd7;

    localparam logic CFG_DAMPING = 1'b0;
    localparam logic CFG_PINNED  = 1'b1;

    localparam logic [15:0] DAMP_RESET = 16'd4588;
    localparam logic [16:0] DAMP_ONE   = 17'd65536;
    localparam int          DAMP_FRAC  = 16;

    function automatic logic signed [31:0] sat_wide(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -66'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = signed'(v[31:0]);
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [65:0] s;
        s = 66'(a) + 66'(b);
        return sat_wide(s);
    endfunction

    function automatic logic signed [31:0] sat_neg(input logic signed [31:0] a);
        logic signed [65:0] s;
        s = -66'(a);
        return sat_wide(s);
    endfunction

endpackage

[src/damped_particle_force_integrator_core.sv]
// Top level of the damped particle integrator with radial force sources.
//
// Usage: one particle is held in Q16.16 state. An item on the item channel
// (item_valid / item_stall) is taken when item_valid is high and item_stall is
// low; item_stall is high from that transaction until its result has been
// placed in the output register. Results leave on the result channel
// (result_valid / result_stall); one result transaction follows each item.
// A tick adds the force to the velocity, damps it in the multiplier and then
// moves the particle (a pinned tick only clears the force); add force, place,
// unused codes and a source with zero reach go straight to the output state,
// and a source outside the square or the circle, or at zero distance, ends there after its range checks.
// An in-range source with nonzero distance runs a 32-step square root and
// three divisions of FRAC_BITS + 1 quotient bits each (17 at Q16.16), one
// after another in the shared root/divide unit, with the single 33 x 33
// multiplier in between. Items are processed one at a time; the next item
// can be taken once the result sits in the output register, even while it
// waits to be collected, so the block never works on two items at once.
// If the receiver stalls, the result register holds and a finished item waits
// until the register is free. Reset clears position, velocity and force,
// loads the damping and pinned registers with their defaults and empties the
// output register. cfg_ready is always high; the user must write configuration
// only while no item is in flight, as the block itself does not enforce it.
module damped_particle_force_integrator_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  dpfi_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output dpfi_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

`include "damped_particle_force_integrator_core_macros.svh"

    localparam int QBITS = FRAC_BITS + 1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_TK_MX,
        S_TK_MY,
        S_TK_WY,
        S_TK_POS,
        S_RANGE,
        S_SQY,
        S_SQR,
        S_CMP,
        S_SQRT,
        S_PCT,
        S_MAG,
        S_UX,
        S_UY,
        S_FX,
        S_FY,
        S_APPLY,
        S_OUT
    } state_t;

    state_t state_reg;

    // Configuration.
    logic [15:0] dmp_reg;
    logic        pin_reg;

    // Particle state.
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic signed [31:0] vel_x_reg, vel_y_reg;
    logic signed [31:0] frc_x_reg, frc_y_reg;

    // Item being worked on.
    logic [2:0]         func_reg;
    logic signed [31:0] pt_x_reg, pt_y_reg;
    logic [30:0]        reach_reg;
    logic signed [31:0] str_reg;

    // Working values of a source force.
    logic signed [32:0]      dx_reg, dy_reg;
    logic [63:0]             sum_reg;
    logic [30:0]             len_reg;
    logic signed [32:0]      mag_reg;
    logic signed [QBITS:0]   ux_reg, uy_reg;
    logic signed [31:0]      fx_reg, fy_reg;
    logic signed [31:0]      rx_reg, ry_reg;
    logic                    hit_reg;

    logic signed [65:0] prod_reg;
    logic               result_valid_reg;
    dpfi_pkg::result_t  result_reg;

    logic signed [32:0] mul_a, mul_b;
    logic [16:0]        factor;
    logic [32:0]        adx, ady;
    logic signed [65:0] rs_frac, rs_damp;
    logic signed [31:0] ox, oy;
    logic [QBITS-1:0]   quo;
    logic signed [QBITS:0] quo_s;

    dpfi_pkg::unit_req_t  u_req;
    dpfi_pkg::unit_stat_t u_stat;
    logic [63:0]          u_operand;
    logic [30:0]          u_divisor;
    logic [31:0]          u_res;

    logic item_take;

    assign item_stall   = (state_reg != S_IDLE);
    assign item_take    = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    dpfi_root_div #(
        .QBITS (QBITS)
    ) u_root_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (u_req),
        .operand (u_operand),
        .divisor (u_divisor),
        .stat    (u_stat),
        .result  (u_res)
    );

    // Velocity keeps (1 - damping) of itself on each tick.
    assign factor = dpfi_pkg::DAMP_ONE - {1'b0, dmp_reg};
    assign adx    = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
    assign ady    = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);

    // Round half up, then drop the fraction bits of the product.
    assign rs_frac = (prod_reg + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    assign rs_damp = (prod_reg + (66'sd1 <<< (dpfi_pkg::DAMP_FRAC - 1))) >>> dpfi_pkg::DAMP_FRAC;

    // A finished quotient of the unit is a unit-vector component in magnitude.
    assign quo   = u_res[QBITS-1:0];
    assign quo_s = signed'({1'b0, quo});

    // Operand selection for the single shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_TK_MX:
            begin
                mul_a = 33'(vel_x_reg);
                mul_b = signed'({16'd0, factor});
            end
            S_TK_MY:
            begin
                mul_a = 33'(vel_y_reg);
                mul_b = signed'({16'd0, factor});
            end
            S_RANGE:
            begin
                mul_a = signed'(adx);
                mul_b = signed'(adx);
            end
            S_SQY:
            begin
                mul_a = signed'(ady);
                mul_b = signed'(ady);
            end
            S_SQR:
            begin
                mul_a = signed'({2'b00, reach_reg});
                mul_b = signed'({2'b00, reach_reg});
            end
            S_PCT:
            begin
                mul_a = 33'(str_reg);
                mul_b = signed'(33'(quo));
            end
            S_UY:
            begin
                mul_a = mag_reg;
                mul_b = 33'(ux_reg);
            end
            S_FX:
            begin
                mul_a = mag_reg;
                mul_b = 33'(uy_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Requests to the root/divide unit.
    always_comb
    begin
        u_req.start = 1'b0;
        u_req.op    = dpfi_pkg::OP_DIV;
        u_operand   = '0;
        u_divisor   = len_reg;
        case (state_reg)
            S_CMP:
            begin
                u_req.start = (sum_reg <= prod_reg[63:0]) && (sum_reg != 64'd0);
                u_req.op    = dpfi_pkg::OP_SQRT;
                u_operand   = sum_reg;
            end
            S_SQRT:
            begin
                // Falloff fraction: (reach - len) / reach.
                u_req.start = u_stat.done;
                u_operand   = 64'({1'b0, reach_reg} - {1'b0, u_res[30:0]}) << FRAC_BITS;
                u_divisor   = reach_reg;
            end
            S_PCT:
            begin
                u_req.start = u_stat.done;
                u_operand   = 64'(adx) << FRAC_BITS;
            end
            S_UX:
            begin
                u_req.start = u_stat.done;
                u_operand   = 64'(ady) << FRAC_BITS;
            end
            default:
            begin
                u_req.start = 1'b0;
            end
        endcase
    end

    // Direction of the own force for each source kind.
    always_comb
    begin
        case (func_reg)
            dpfi_pkg::FN_REPEL:
            begin
                ox = fx_reg;
                oy = fy_reg;
            end
            dpfi_pkg::FN_ATTRACT:
            begin
                ox = dpfi_pkg::sat_neg(fx_reg);
                oy = dpfi_pkg::sat_neg(fy_reg);
            end
            dpfi_pkg::FN_CW:
            begin
                ox = dpfi_pkg::sat_neg(fy_reg);
                oy = fx_reg;
            end
            default:
            begin
                ox = fy_reg;
                oy = dpfi_pkg::sat_neg(fx_reg);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            dmp_reg          <= dpfi_pkg::DAMP_RESET;
            pin_reg          <= 1'b0;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            vel_x_reg        <= '0;
            vel_y_reg        <= '0;
            frc_x_reg        <= '0;
            frc_y_reg        <= '0;
            func_reg         <= '0;
            pt_x_reg         <= '0;
            pt_y_reg         <= '0;
            reach_reg        <= '0;
            str_reg          <= '0;
            dx_reg           <= '0;
            dy_reg           <= '0;
            sum_reg          <= '0;
            len_reg          <= '0;
            mag_reg          <= '0;
            ux_reg           <= '0;
            uy_reg           <= '0;
            fx_reg           <= '0;
            fy_reg           <= '0;
            rx_reg           <= '0;
            ry_reg           <= '0;
            hit_reg          <= 1'b0;
            prod_reg         <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            prod_reg <= mul_a * mul_b;

            if (cfg_valid)
            begin
                case (cfg_index)
                    dpfi_pkg::CFG_DAMPING: dmp_reg <= cfg_data;
                    dpfi_pkg::CFG_PINNED:  pin_reg <= cfg_data[0];
                    default:               dmp_reg <= dmp_reg;
                endcase
            end

            // The output state refills the register itself when it is taken.
            if (result_valid_reg && !result_stall && (state_reg != S_OUT))
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (item_take)
                    begin
                        func_reg  <= item.func;
                        pt_x_reg  <= item.point_x;
                        pt_y_reg  <= item.point_y;
                        reach_reg <= item.reach;
                        str_reg   <= item.strength;
                        rx_reg    <= '0;
                        ry_reg    <= '0;
                        hit_reg   <= 1'b0;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    case (func_reg)
                        dpfi_pkg::FN_TICK:
                        begin
                            if (pin_reg)
                            begin
                                frc_x_reg <= '0;
                                frc_y_reg <= '0;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                vel_x_reg <= dpfi_pkg::sat_add(vel_x_reg, frc_x_reg);
                                vel_y_reg <= dpfi_pkg::sat_add(vel_y_reg, frc_y_reg);
                                state_reg <= S_TK_MX;
                            end
                        end
                        dpfi_pkg::FN_ADD:
                        begin
                            frc_x_reg <= dpfi_pkg::sat_add(frc_x_reg, pt_x_reg);
                            frc_y_reg <= dpfi_pkg::sat_add(frc_y_reg, pt_y_reg);
                            state_reg <= S_OUT;
                        end
                        dpfi_pkg::FN_PLACE:
                        begin
                            pos_x_reg <= pt_x_reg;
                            pos_y_reg <= pt_y_reg;
                            state_reg <= S_OUT;
                        end
                        dpfi_pkg::FN_REPEL,
                        dpfi_pkg::FN_ATTRACT,
                        dpfi_pkg::FN_CW,
                        dpfi_pkg::FN_CCW:
                        begin
                            dx_reg <= 33'(pos_x_reg) - 33'(pt_x_reg);
                            dy_reg <= 33'(pos_y_reg) - 33'(pt_y_reg);
                            state_reg <= (reach_reg == 31'd0) ? S_OUT : S_RANGE;
                        end
                        default:
                        begin
                            state_reg <= S_OUT;
                        end
                    endcase
                end
                S_TK_MX:
                begin
                    state_reg <= S_TK_MY;
                end
                S_TK_MY:
                begin
                    vel_x_reg <= dpfi_pkg::sat_wide(rs_damp);
                    state_reg <= S_TK_WY;
                end
                S_TK_WY:
                begin
                    vel_y_reg <= dpfi_pkg::sat_wide(rs_damp);
                    state_reg <= S_TK_POS;
                end
                S_TK_POS:
                begin
                    pos_x_reg <= dpfi_pkg::sat_add(pos_x_reg, vel_x_reg);
                    pos_y_reg <= dpfi_pkg::sat_add(pos_y_reg, vel_y_reg);
                    frc_x_reg <= '0;
                    frc_y_reg <= '0;
                    state_reg <= S_OUT;
                end
                S_RANGE:
                begin
                    if ((adx <= {2'b00, reach_reg}) && (ady <= {2'b00, reach_reg}))
                    begin
                        state_reg <= S_SQY;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_SQY:
                begin
                    sum_reg   <= prod_reg[63:0];
                    state_reg <= S_SQR;
                end
                S_SQR:
                begin
                    sum_reg   <= sum_reg + prod_reg[63:0];
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (sum_reg <= prod_reg[63:0])
                    begin
                        hit_reg <= 1'b1;
                        // At zero distance the force is zero and the sums stay as they are.
                        state_reg <= (sum_reg == 64'd0) ? S_OUT : S_SQRT;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_SQRT:
                begin
                    if (u_stat.done)
                    begin
                        len_reg   <= u_res[30:0];
                        state_reg <= S_PCT;
                    end
                end
                S_PCT:
                begin
                    if (u_stat.done)
                    begin
                        state_reg <= S_MAG;
                    end
                end
                S_MAG:
                begin
                    mag_reg   <= rs_frac[32:0];
                    state_reg <= S_UX;
                end
                S_UX:
                begin
                    if (u_stat.done)
                    begin
                        ux_reg    <= dx_reg[32] ? -quo_s : quo_s;
                        state_reg <= S_UY;
                    end
                end
                S_UY:
                begin
                    if (u_stat.done)
                    begin
                        uy_reg    <= dy_reg[32] ? -quo_s : quo_s;
                        state_reg <= S_FX;
                    end
                end
                S_FX:
                begin
                    fx_reg    <= dpfi_pkg::sat_wide(rs_frac);
                    state_reg <= S_FY;
                end
                S_FY:
                begin
                    fy_reg    <= dpfi_pkg::sat_wide(rs_frac);
                    state_reg <= S_APPLY;
                end
                S_APPLY:
                begin
                    frc_x_reg <= dpfi_pkg::sat_add(frc_x_reg, ox);
                    frc_y_reg <= dpfi_pkg::sat_add(frc_y_reg, oy);
                    rx_reg    <= dpfi_pkg::sat_neg(ox);
                    ry_reg    <= dpfi_pkg::sat_neg(oy);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!result_valid_reg || !result_stall)
                    begin
                        result_reg.pos_x      <= pos_x_reg;
                        result_reg.pos_y      <= pos_y_reg;
                        result_reg.reaction_x <= rx_reg;
                        result_reg.reaction_y <= ry_reg;
                        result_reg.in_range   <= hit_reg;
                        result_valid_reg      <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // An accepted item always leaves the idle state.
    `DPFI_ASSERT_NXT(a_take_busy, item_take, state_reg != S_IDLE, "item accepted but block stayed idle")
    // The shared unit only finishes while the sequencer is waiting for it.
    `DPFI_ASSERT_IMP(a_unit_wait, u_stat.done, (state_reg == S_SQRT) || (state_reg == S_PCT) || (state_reg == S_UX) || (state_reg == S_UY), "unit finished outside a wait state")
    // A new result only appears from the output state.
    `DPFI_ASSERT_IMP(a_result_src, $rose(result_valid_reg), $past(state_reg) == S_OUT, "result valid without a finished item")
    // A tick always leaves the accumulated force cleared.
    `DPFI_ASSERT_NXT(a_tick_clear, state_reg == S_TK_POS, (frc_x_reg == 32'sd0) && (frc_y_reg == 32'sd0), "force not cleared by tick")

endmodule

[src/dpfi_root_div.sv]
// Shared iterative unit: integer square root and restoring division.
module dpfi_root_div #(
    parameter int QBITS = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dpfi_pkg::unit_req_t  req,
    input  logic [63:0]          operand,
    input  logic [30:0]          divisor,
    output dpfi_pkg::unit_stat_t stat,
    output logic [31:0]          result
);

    localparam int SQRT_STEPS = 32;

    dpfi_pkg::unit_op_t op_reg;
    logic [5:0]  cnt_reg;
    logic [35:0] rem_reg;
    logic [63:0] shf_reg;
    logic [31:0] res_reg;
    logic [30:0] div_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [35:0] cand;
    logic [35:0] trial;
    logic [36:0] diff;
    logic        ge;

    // One subtractor serves both operations: a root digit or a quotient bit per cycle.
    always_comb
    begin
        if (op_reg == dpfi_pkg::OP_SQRT)
        begin
            cand  = {rem_reg[33:0], shf_reg[63:62]};
            trial = {2'b00, res_reg, 2'b01};
        end
        else
        begin
            cand  = {3'b000, rem_reg[31:0], shf_reg[63]};
            trial = {5'b00000, div_reg};
        end
        diff = {1'b0, cand} - {1'b0, trial};
        ge   = ~diff[36];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= dpfi_pkg::OP_SQRT;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            shf_reg  <= '0;
            res_reg  <= '0;
            div_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                op_reg   <= req.op;
                res_reg  <= '0;
                div_reg  <= divisor;
                busy_reg <= 1'b1;
                if (req.op == dpfi_pkg::OP_SQRT)
                begin
                    rem_reg <= '0;
                    shf_reg <= operand;
                    cnt_reg <= 6'(SQRT_STEPS);
                end
                else
                begin
                    // The quotient fits in QBITS bits, so the upper part is below the divisor.
                    rem_reg <= 36'(operand >> QBITS);
                    shf_reg <= operand << (64 - QBITS);
                    cnt_reg <= 6'(QBITS);
                end
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[35:0] : cand;
                res_reg <= {res_reg[30:0], ge};
                shf_reg <= (op_reg == dpfi_pkg::OP_SQRT) ? (shf_reg << 2) : (shf_reg << 1);
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = res_reg;

endmodule
